### rtl/core/pfc_pkg.sv
// Shared types, format codes and helper functions for the pixel format converter.
`default_nettype none

package pfc_pkg;

  typedef enum logic [3:0] {
    FMT_INVALID  = 4'd0,
    FMT_RGBA8888 = 4'd1,
    FMT_RGBA4444 = 4'd2,
    FMT_RGBA5551 = 4'd3,
    FMT_RGB888   = 4'd4,
    FMT_RGB565   = 4'd5,
    FMT_RGB555   = 4'd6,
    FMT_RGB444   = 4'd7,
    FMT_L8       = 4'd8,
    FMT_A8       = 4'd9,
    FMT_LA88     = 4'd10,
    FMT_RGBAF    = 4'd11,
    FMT_RGB332   = 4'd12,
    FMT_BGR888   = 4'd13
  } fmt_t;

  typedef enum logic [1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_TARGET_FORMAT = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgba_t;

  localparam logic [15:0] LUMA_R = 16'd54;
  localparam logic [15:0] LUMA_G = 16'd183;
  localparam logic [15:0] LUMA_B = 16'd18;

  function automatic logic [31:0] fmt_width_mask(input fmt_t fmt);
    logic [31:0] mask;
    unique case (fmt)
      FMT_RGBA8888:                        mask = 32'hFFFF_FFFF;
      FMT_RGB888, FMT_BGR888:              mask = 32'h00FF_FFFF;
      FMT_RGBA4444, FMT_RGBA5551, FMT_RGB565,
      FMT_RGB555, FMT_RGB444, FMT_LA88:    mask = 32'h0000_FFFF;
      FMT_L8, FMT_A8, FMT_RGB332:          mask = 32'h0000_00FF;
      default:                             mask = 32'h0000_0000;
    endcase
    return mask;
  endfunction

  // Float and undefined codes have no width and count as unsupported.
  function automatic logic fmt_supported(input fmt_t fmt);
    return fmt_width_mask(fmt) != 32'd0;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pfc_unpack.sv
// Unpacks a source pixel to 8-bit RGBA by bit replication.
`default_nettype none

module pfc_unpack
  import pfc_pkg::*;
(
  input  fmt_t        fmt,
  input  logic [31:0] pixel,
  output rgba_t       color
);

  always_comb begin
    color = '{a: 8'hFF, b: 8'hFF, g: 8'hFF, r: 8'hFF};
    unique case (fmt)
      FMT_RGBA8888: begin
        color = rgba_t'(pixel);
      end
      FMT_RGBA4444: begin
        color.r = {pixel[15:12], pixel[15:12]};
        color.g = {pixel[11:8], pixel[11:8]};
        color.b = {pixel[7:4], pixel[7:4]};
        color.a = {pixel[3:0], pixel[3:0]};
      end
      FMT_RGBA5551, FMT_RGB555: begin
        color.r = {pixel[15:11], pixel[15:13]};
        color.g = {pixel[10:6], pixel[10:8]};
        color.b = {pixel[5:1], pixel[5:3]};
        if (fmt == FMT_RGBA5551) begin
          color.a = {8{pixel[0]}};
        end
      end
      FMT_RGB888: begin
        color.r = pixel[7:0];
        color.g = pixel[15:8];
        color.b = pixel[23:16];
      end
      FMT_RGB565: begin
        color.r = {pixel[15:11], pixel[15:13]};
        color.g = {pixel[10:5], pixel[10:9]};
        color.b = {pixel[4:0], pixel[4:2]};
      end
      FMT_RGB444: begin
        color.r = {pixel[15:12], pixel[15:12]};
        color.g = {pixel[11:8], pixel[11:8]};
        color.b = {pixel[7:4], pixel[7:4]};
      end
      FMT_L8: begin
        color.r = pixel[7:0];
        color.g = pixel[7:0];
        color.b = pixel[7:0];
      end
      FMT_A8: begin
        color.a = pixel[7:0];
      end
      FMT_LA88: begin
        color.r = pixel[7:0];
        color.g = pixel[7:0];
        color.b = pixel[7:0];
        color.a = pixel[15:8];
      end
      FMT_RGB332: begin
        color.r = {pixel[7:5], pixel[7:5], pixel[7:6]};
        color.g = {pixel[4:2], pixel[4:2], pixel[4:3]};
        color.b = {4{pixel[1:0]}};
      end
      FMT_BGR888: begin
        color.b = pixel[7:0];
        color.g = pixel[15:8];
        color.r = pixel[23:16];
      end
      default: begin
        color = '{a: 8'hFF, b: 8'hFF, g: 8'hFF, r: 8'hFF};
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/pfc_pack.sv
// Packs 8-bit RGBA into a target format by truncation, with integer luma for grey.
`default_nettype none

module pfc_pack
  import pfc_pkg::*;
(
  input  fmt_t        fmt,
  input  rgba_t       color,
  output logic [31:0] pixel
);

  logic [15:0] luma_sum;
  logic [7:0]  luma;

  assign luma_sum = LUMA_R * {8'd0, color.r} + LUMA_G * {8'd0, color.g}
                  + LUMA_B * {8'd0, color.b};
  assign luma = luma_sum[15:8];

  always_comb begin
    unique case (fmt)
      FMT_RGBA8888: pixel = {color.a, color.b, color.g, color.r};
      FMT_RGBA4444: pixel = {16'd0, color.r[7:4], color.g[7:4], color.b[7:4], color.a[7:4]};
      FMT_RGBA5551: pixel = {16'd0, color.r[7:3], color.g[7:3], color.b[7:3], color.a[7]};
      FMT_RGB888:   pixel = {8'd0, color.b, color.g, color.r};
      FMT_RGB565:   pixel = {16'd0, color.r[7:3], color.g[7:2], color.b[7:3]};
      FMT_RGB555:   pixel = {16'd0, color.r[7:3], color.g[7:3], color.b[7:3], 1'b1};
      FMT_RGB444:   pixel = {16'd0, color.r[7:4], color.g[7:4], color.b[7:4], 4'hF};
      FMT_L8:       pixel = {24'd0, luma};
      FMT_A8:       pixel = {24'd0, color.a};
      FMT_LA88:     pixel = {16'd0, color.a, luma};
      FMT_RGB332:   pixel = {24'd0, color.r[7:5], color.g[7:5], color.b[7:6]};
      FMT_BGR888:   pixel = {8'd0, color.r, color.g, color.b};
      default:      pixel = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/pixel_format_converter_core.sv
// Top level of the pixel format converter: config registers, request and result stages.
//
// Usage:
//   Program source_format and target_format through the cfg channel (cfg_index 0
//   and 1, cfg_data holds the 4-bit format code) while no pixel is in flight.
//   cfg_ready is always high; other indexes are ignored.
//   Issue a pixel request by raising start with pixel_in and last_in. busy is
//   always low, so a request is taken on every cycle that start is high.
//   Each request is registered in the request stage, converted by one pass through
//   the unpack and pack logic, and registered again in the result stage: done pulses
//   for one cycle with pixel_out, valid_out and last_out.
//   Throughput is one pixel per clock; the unpack/pack path with its luma
//   multiply-add sets the cycle time.
//   valid_out is low, and pixel_out zero, when either format is unsupported.
//   The receiver cannot stall: results must be taken in the cycle done is high.
//   Reset clears both format registers to invalid and drops any request in flight.
`default_nettype none

module pixel_format_converter_core
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pixel_in,
  input  logic        last_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [31:0] pixel_out,
  output logic        valid_out,
  output logic        last_out
);

  fmt_t        source_format;
  fmt_t        target_format;
  logic        req_valid;
  logic [31:0] req_pixel;
  logic        req_last;

  logic [31:0] src_pixel;
  logic        fmt_ok;
  rgba_t       color;
  logic [31:0] conv_pixel;
  logic [31:0] pixel_out_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_INVALID;
      target_format <= FMT_INVALID;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_SOURCE_FORMAT: source_format <= fmt_t'(cfg_data);
        REG_TARGET_FORMAT: target_format <= fmt_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_pixel <= pixel_in;
      req_last  <= last_in;
    end
  end

  assign src_pixel = req_pixel & fmt_width_mask(source_format);
  assign fmt_ok    = fmt_supported(source_format) && fmt_supported(target_format);

  pfc_unpack u_unpack (
    .fmt   (source_format),
    .pixel (src_pixel),
    .color (color)
  );

  pfc_pack u_pack (
    .fmt   (target_format),
    .color (color),
    .pixel (conv_pixel)
  );

  always_comb begin
    priority if (!fmt_ok) begin
      pixel_out_next = 32'd0;
    end else if (source_format == target_format) begin
      pixel_out_next = src_pixel;
    end else begin
      pixel_out_next = conv_pixel;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      pixel_out <= pixel_out_next;
      valid_out <= fmt_ok;
      last_out  <= req_last;
    end
  end

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing two cycles after request");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(start && !busy, 2) && !$past(rst) && !$past(rst, 2)) |-> !done)
    else $error("result strobe without a request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_out) |-> (pixel_out == 32'd0))
    else $error("unsupported format gave nonzero pixel");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !rst) |=> ##1 (last_out == $past(last_in, 2)))
    else $error("last flag not carried to result");

endmodule

`default_nettype wire

### dv/tb_pixel_format_converter_core.sv
// Self-checking testbench for the pixel format converter core.
`timescale 1ns / 100ps

module tb_pixel_format_converter_core;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PIXELS = 200;

  // Codes with no format behind them.
  localparam logic [3:0] FMT_UNDEF_LO = 4'd14;
  localparam logic [3:0] FMT_UNDEF_HI = 4'd15;

  localparam logic [16:0] LUMA_WR = 17'd54;
  localparam logic [16:0] LUMA_WG = 17'd183;
  localparam logic [16:0] LUMA_WB = 17'd18;

  typedef struct packed {
    logic [31:0] pixel;
    logic        valid;
    logic        last;
  } conv_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] pixel_in;
  logic        last_in;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_index_t  cfg_index;
  logic [3:0]  cfg_data;
  logic        done;
  logic [31:0] pixel_out;
  logic        valid_out;
  logic        last_out;

  conv_result_t conv_expect_q[$];
  logic [3:0]   src_fmt_m;
  logic [3:0]   dst_fmt_m;
  int           err_count;
  int           results_checked;
  int           pixels_sent;
  int           settings_used;
  int           cycle_count;
  int           sender_idle_pct;

  const fmt_t supported_fmts[12] = '{FMT_RGBA8888, FMT_RGBA4444, FMT_RGBA5551, FMT_RGB888,
    FMT_RGB565, FMT_RGB555, FMT_RGB444, FMT_L8, FMT_A8, FMT_LA88, FMT_RGB332, FMT_BGR888};
  const int idle_phases[3] = '{0, 56, 14};

  pixel_format_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_in  (pixel_in),
    .last_in   (last_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .pixel_out (pixel_out),
    .valid_out (valid_out),
    .last_out  (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- conversion predictor ----------------

  function automatic int fmt_width(input logic [3:0] code);
    case (code)
      FMT_RGBA8888:                         return 32;
      FMT_RGB888, FMT_BGR888:               return 24;
      FMT_RGBA4444, FMT_RGBA5551, FMT_RGB565,
      FMT_RGB555, FMT_RGB444, FMT_LA88:     return 16;
      FMT_L8, FMT_A8, FMT_RGB332:           return 8;
      default:                              return 0;
    endcase
  endfunction

  function automatic logic [31:0] fmt_mask(input logic [3:0] code);
    int w;
    w = fmt_width(code);
    return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
  endfunction

  function automatic logic [7:0] grey_level(input rgba_t c);
    logic [16:0] sum;
    sum = LUMA_WR * c.r + LUMA_WG * c.g + LUMA_WB * c.b;
    return sum[15:8];
  endfunction

  function automatic rgba_t expand_channels(input logic [3:0] code, input logic [31:0] p);
    rgba_t c;
    c = '1;
    case (code)
      FMT_RGBA8888: c = rgba_t'(p);
      FMT_RGBA4444: begin
        c.r = {2{p[15:12]}};
        c.g = {2{p[11:8]}};
        c.b = {2{p[7:4]}};
        c.a = {2{p[3:0]}};
      end
      FMT_RGBA5551, FMT_RGB555: begin
        c.r = {p[15:11], p[15:13]};
        c.g = {p[10:6], p[10:8]};
        c.b = {p[5:1], p[5:3]};
        if (code == FMT_RGBA5551) c.a = {8{p[0]}};
      end
      FMT_RGB888: begin
        c.r = p[7:0];
        c.g = p[15:8];
        c.b = p[23:16];
      end
      FMT_RGB565: begin
        c.r = {p[15:11], p[15:13]};
        c.g = {p[10:5], p[10:9]};
        c.b = {p[4:0], p[4:2]};
      end
      FMT_RGB444: begin
        c.r = {2{p[15:12]}};
        c.g = {2{p[11:8]}};
        c.b = {2{p[7:4]}};
      end
      FMT_L8: begin
        c.r = p[7:0];
        c.g = p[7:0];
        c.b = p[7:0];
      end
      FMT_A8: c.a = p[7:0];
      FMT_LA88: begin
        c.r = p[7:0];
        c.g = p[7:0];
        c.b = p[7:0];
        c.a = p[15:8];
      end
      FMT_RGB332: begin
        c.r = {p[7:5], p[7:5], p[7:6]};
        c.g = {p[4:2], p[4:2], p[4:3]};
        c.b = {4{p[1:0]}};
      end
      default: begin
        c.b = p[7:0];
        c.g = p[15:8];
        c.r = p[23:16];
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] repack_channels(input logic [3:0] code, input rgba_t c);
    logic [31:0] p;
    case (code)
      FMT_RGBA8888: p = 32'(c);
      FMT_RGBA4444: p = {16'd0, c.r[7:4], c.g[7:4], c.b[7:4], c.a[7:4]};
      FMT_RGBA5551: p = {16'd0, c.r[7:3], c.g[7:3], c.b[7:3], c.a[7]};
      FMT_RGB888:   p = {8'd0, c.b, c.g, c.r};
      FMT_RGB565:   p = {16'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
      FMT_RGB555:   p = {16'd0, c.r[7:3], c.g[7:3], c.b[7:3], 1'b1};
      FMT_RGB444:   p = {16'd0, c.r[7:4], c.g[7:4], c.b[7:4], 4'hF};
      FMT_L8:       p = {24'd0, grey_level(c)};
      FMT_A8:       p = {24'd0, c.a};
      FMT_LA88:     p = {16'd0, c.a, grey_level(c)};
      FMT_RGB332:   p = {24'd0, c.r[7:5], c.g[7:5], c.b[7:6]};
      default:      p = {8'd0, c.r, c.g, c.b};
    endcase
    return p & fmt_mask(code);
  endfunction

  function automatic conv_result_t convert_pixel(input logic [3:0] src, input logic [3:0] dst,
                                                 input logic [31:0] p, input logic lst);
    conv_result_t r;
    r.pixel = '0;
    r.valid = (fmt_width(src) != 0) && (fmt_width(dst) != 0);
    r.last  = lst;
    if (r.valid) begin
      if (src == dst) r.pixel = p & fmt_mask(src);
      else r.pixel = repack_channels(dst, expand_channels(src, p & fmt_mask(src)));
    end
    return r;
  endfunction

  // ---------------- result check and format tracking ----------------

  always @(posedge clk) begin
    conv_result_t want;
    if (rst) begin
      src_fmt_m = FMT_INVALID;
      dst_fmt_m = FMT_INVALID;
    end else begin
      if (done) begin
        if (conv_expect_q.size() == 0) begin
          $display("%0t: unexpected result pixel_out %h valid_out %b last_out %b",
                   $time, pixel_out, valid_out, last_out);
          err_count++;
        end else begin
          want = conv_expect_q.pop_front();
          results_checked++;
          if (pixel_out !== want.pixel) begin
            $display("%0t: pixel_out expected %h, got %h", $time, want.pixel, pixel_out);
            err_count++;
          end
          if (valid_out !== want.valid) begin
            $display("%0t: valid_out expected %b, got %b", $time, want.valid, valid_out);
            err_count++;
          end
          if (last_out !== want.last) begin
            $display("%0t: last_out expected %b, got %b", $time, want.last, last_out);
            err_count++;
          end
        end
      end
      if (start && !busy)
        conv_expect_q.push_back(convert_pixel(src_fmt_m, dst_fmt_m, pixel_in, last_in));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_FORMAT: src_fmt_m = cfg_data;
          REG_TARGET_FORMAT: dst_fmt_m = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, conv_expect_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- drivers (entered and left at a falling edge) ----------------

  task automatic send_pixel(input logic [31:0] px, input logic lst);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    pixel_in <= px;
    last_in  <= lst;
    do @(posedge clk); while (busy);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (conv_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_formats(input logic [3:0] src, input logic [3:0] dst);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SOURCE_FORMAT;
    cfg_data  <= src;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_TARGET_FORMAT;
    cfg_data  <= dst;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] random_pixel();
    logic [31:0] bit_sel;
    bit_sel = 32'd1 << $urandom_range(31);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return bit_sel;
      3:       return ~bit_sel;
      default: return $urandom;
    endcase
  endfunction

  // ---------------- tests ----------------

  // Formats come out of reset invalid.
  task automatic test_reset_formats();
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h1234_5678, 1'b0);
  endtask

  task automatic test_unsupported_codes();
    set_formats(FMT_RGBAF, FMT_RGB565);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    set_formats(FMT_RGB888, FMT_UNDEF_LO);
    send_pixel(32'h00AB_CDEF, 1'b0);
    set_formats(FMT_UNDEF_HI, FMT_L8);
    send_pixel(32'h0000_00FF, 1'b1);
    set_formats(FMT_RGBA8888, FMT_INVALID);
    send_pixel(32'h8000_0001, 1'b1);
  endtask

  // Same format on both sides: bits above the width must drop.
  task automatic test_pass_through();
    set_formats(FMT_RGBA8888, FMT_RGBA8888);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    set_formats(FMT_RGB565, FMT_RGB565);
    send_pixel(32'hFFFF_A5A5, 1'b1);
    set_formats(FMT_RGB332, FMT_RGB332);
    send_pixel(32'hABCD_EF96, 1'b0);
  endtask

  task automatic test_channel_extremes();
    set_formats(FMT_RGB565, FMT_RGBA8888);
    send_pixel(32'h0000_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_07E0, 1'b1);
    set_formats(FMT_RGBA8888, FMT_L8);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h00FF_0000, 1'b1);
    set_formats(FMT_RGBA5551, FMT_A8);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'h0000_FFFE, 1'b1);
    set_formats(FMT_RGB332, FMT_BGR888);
    send_pixel(32'h0000_00FF, 1'b0);
    send_pixel(32'h0000_006D, 1'b1);
    set_formats(FMT_LA88, FMT_RGBA4444);
    send_pixel(32'h0000_80FF, 1'b1);
    set_formats(FMT_A8, FMT_RGB555);
    send_pixel(32'h0000_00C3, 1'b0);
    set_formats(FMT_RGB444, FMT_LA88);
    send_pixel(32'h0000_F0F0, 1'b1);
  endtask

  // Sweep every code pair, extremes and unused codes included.
  task automatic test_all_format_pairs();
    for (int s = 0; s < 16; s++) begin
      for (int d = 0; d < 16; d++) begin
        set_formats(4'(s), 4'(d));
        sender_idle_pct = idle_phases[((s * 16 + d) / 8) % 3];
        repeat (2) send_pixel(random_pixel(), 1'($urandom_range(1)));
      end
    end
  endtask

  // Line bursts on mostly supported pairs, with equal pairs favored.
  task automatic test_random_sessions();
    int sent;
    int burst;
    logic [3:0] src;
    logic [3:0] dst;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(99) < 85) src = supported_fmts[$urandom_range(11)];
      else src = 4'($urandom_range(15));
      if ($urandom_range(99) < 20) dst = src;
      else if ($urandom_range(99) < 85) dst = supported_fmts[$urandom_range(11)];
      else dst = 4'($urandom_range(15));
      set_formats(src, dst);
      sender_idle_pct = idle_phases[$urandom_range(2)];
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst; i++)
        send_pixel(random_pixel(), (i == burst - 1) || ($urandom_range(7) == 0));
      sent += burst;
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    pixel_in        = '0;
    last_in         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SOURCE_FORMAT;
    cfg_data        = '0;
    err_count       = 0;
    results_checked = 0;
    pixels_sent     = 0;
    settings_used   = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    src_fmt_m       = FMT_INVALID;
    dst_fmt_m       = FMT_INVALID;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_formats();
    test_unsupported_codes();
    test_pass_through();
    test_channel_extremes();
    test_all_format_pairs();
    test_random_sessions();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels under %0d format settings (all 256 code pairs swept),",
             pixels_sent, settings_used);
    $display("checked %0d results with idle-free and idle-heavy request streams.",
             results_checked);
    if (err_count == 0 && conv_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_count, conv_expect_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
